[rtl/rdq_pkg.sv]
package rdq_pkg;

  // Fixed field widths of the request and result transactions
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned FILL_W    = 5;

  // Default ring depth
  localparam int unsigned DEPTH_DEF = 16;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_REAR  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_POP_REAR   = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_DENIED = 2'd3
  } status_t;

  // Restriction mode register values
  localparam logic MODE_IN_RESTRICT  = 1'b0;
  localparam logic MODE_OUT_RESTRICT = 1'b1;

endpackage

[rtl/rdq_slot_ram.sv]
module rdq_slot_ram #(
  parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic                              re,
  input  logic [$clog2(DEPTH)-1:0]          addr,
  input  logic [rdq_pkg::VALUE_W-1:0]       wdata,
  output logic [rdq_pkg::VALUE_W-1:0]       rdata
);
  import rdq_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  // Write one slot per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Register read data; hold it until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/restricted_deque.sv]
// Bounded double-ended queue of signed 32-bit words held in a DEPTH-entry ring
// memory with a front index and a fill count. Each request transaction (push
// front, push rear, pop front, pop rear) returns exactly one result
// transaction with status, popped word (zero unless a pop succeeded), fill
// count (modulo 32) and an empty flag. cfg_wdata selects the restriction:
// 0 refuses push front, 1 refuses pop rear; write it only while idle. A
// request is accepted every cycle when results are taken; its result passes
// through the synchronous memory read of the popped slot in the read stage and
// then through the output register. Pointers update at acceptance,
// so back-to-back requests touching the same slot need no interlock. The ring
// memory needs no clearing after reset.
module restricted_deque #(
  parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rdq_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [rdq_pkg::VALUE_W-1:0] in_value,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rdq_pkg::VALUE_W-1:0] out_popped_value,
  output logic [rdq_pkg::STATUS_W-1:0]      out_status,
  output logic [rdq_pkg::FILL_W-1:0]        out_fill_count,
  output logic                              out_is_empty
);
  import rdq_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned EXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  // Control state
  logic                 mode_r;
  logic [IDX_W-1:0]     front_r, front_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // Read stage
  logic                 s1_valid_r;
  logic                 s1_pop_r;
  status_t              s1_status_r;
  logic [CNT_W-1:0]     s1_cnt_r;

  // Output register
  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_value_r;
  status_t              out_status_r;
  logic [FILL_W-1:0]    out_fill_r;
  logic                 out_empty_r;

  logic                 in_acc;
  logic                 s1_move;
  func_t                func;
  logic                 is_push;
  logic                 denied;
  status_t              status;
  logic                 req_ok;
  logic [IDX_W-1:0]     front_dec;
  logic [IDX_W-1:0]     front_inc;
  logic [SUM_W-1:0]     rear_sum;
  logic [SUM_W-1:0]     last_sum;
  logic [SUM_W-1:0]     rear_wrap;
  logic [SUM_W-1:0]     last_wrap;
  logic [IDX_W-1:0]     ram_addr;
  logic                 ram_we;
  logic                 ram_re;
  logic [VALUE_W-1:0]   ram_rdata;
  logic [EXT_W-1:0]     s1_cnt_ext;

  assign func    = func_t'(in_func);
  assign is_push = (func == FN_PUSH_FRONT) || (func == FN_PUSH_REAR);

  // Hand off the read stage when the output register is free or drains
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign in_acc   = in_valid && in_ready;

  // Classify the request: mode check first, then full and empty
  always_comb begin
    denied = ((mode_r == MODE_IN_RESTRICT) && (func == FN_PUSH_FRONT)) ||
             ((mode_r == MODE_OUT_RESTRICT) && (func == FN_POP_REAR));
    if (denied) begin
      status = ST_DENIED;
    end else if (is_push && (cnt_r == CNT_W'(DEPTH))) begin
      status = ST_FULL;
    end else if (!is_push && (cnt_r == '0)) begin
      status = ST_EMPTY;
    end else begin
      status = ST_OK;
    end
  end

  assign req_ok = (status == ST_OK);

  // Ring index arithmetic, wrapping by compare instead of modulo
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign rear_sum  = SUM_W'(front_r) + SUM_W'(cnt_r);
  assign last_sum  = rear_sum - 1'b1;
  assign rear_wrap = (rear_sum >= SUM_W'(DEPTH)) ? rear_sum - SUM_W'(DEPTH) : rear_sum;
  assign last_wrap = (last_sum >= SUM_W'(DEPTH)) ? last_sum - SUM_W'(DEPTH) : last_sum;

  // Pick the slot and the pointer updates for each request code
  always_comb begin
    front_nxt = front_r;
    cnt_nxt   = cnt_r;
    case (func)
      FN_PUSH_FRONT: begin
        ram_addr = front_dec;
        if (req_ok) begin
          front_nxt = front_dec;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      FN_PUSH_REAR: begin
        ram_addr = rear_wrap[IDX_W-1:0];
        if (req_ok) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        ram_addr = front_r;
        if (req_ok) begin
          front_nxt = front_inc;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      FN_POP_REAR: begin
        ram_addr = last_wrap[IDX_W-1:0];
        if (req_ok) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        ram_addr = front_r;
      end
    endcase
  end

  assign ram_we = in_acc && req_ok && is_push;
  assign ram_re = in_acc && req_ok && !is_push;

  rdq_slot_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IN_RESTRICT;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Advance ring pointers at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      cnt_r   <= '0;
    end else if (in_acc) begin
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Read stage: wait for the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pop_r    <= req_ok && !is_push;
      s1_status_r <= status;
      s1_cnt_r    <= cnt_nxt;
    end
  end

  assign s1_cnt_ext = EXT_W'(s1_cnt_r);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_value_r  <= s1_pop_r ? ram_rdata : '0;
      out_status_r <= s1_status_r;
      out_fill_r   <= s1_cnt_ext[FILL_W-1:0];
      out_empty_r  <= (s1_cnt_r == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_fill_count   = out_fill_r;
  assign out_is_empty     = out_empty_r;

  // Count never exceeds the ring depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // Front index stays inside the ring
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= IDX_W'(DEPTH - 1))
    else $error("front index outside ring");

  // A successful push grows the count by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && req_ok && is_push) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("push did not grow count");

  // A refused request leaves the pointers alone
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !req_ok) |=> ($stable(cnt_r) && $stable(front_r)))
    else $error("refused request moved pointers");

  // A refused request returns a zero word
  a_pop_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_value_r == '0))
    else $error("refused request returned data");

endmodule
